>>> rtl/tlm_pkg.sv
package tlm_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned LIST_DEPTH = 32;

  // Command codes carried in the func field of an input item.
  localparam logic [1:0] FUNC_APPEND_A = 2'd0;
  localparam logic [1:0] FUNC_APPEND_B = 2'd1;
  localparam logic [1:0] FUNC_MERGE    = 2'd2;

  typedef struct packed {
    logic [1:0]                   func;
    logic signed [DATA_WIDTH-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] merged_value;
    logic                         last;
    logic                         dropped;
  } out_item_t;

endpackage

>>> rtl/tlm_ram.sv
module tlm_ram #(
  parameter int unsigned Width     = 32,
  parameter int unsigned Depth     = 32,
  parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read returns the contents before a write at the same edge.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/two_list_merge_core.sv
// Channel | Direction | Handshake                 | Payload
// --------+-----------+---------------------------+------------------------------------------
// in      | input     | in_valid_i / in_ready_o   | in_item_i  (func, value)
// out     | output    | out_valid_o / out_ready_i | out_item_o (merged_value, last, dropped)
//
// An append item is accepted on every cycle while no merge runs.
// A merge of NA + NB stored values fetches both heads in its own cycle and holds the input
// until its last result is emitted; the output register passes one result per cycle when free.
// Reset clears both fill counts, the drop flag and the sequencer; the list memories keep
// their contents, since only entries written since the last merge are read.
// A stalled output holds the merge pointers, so both heads stay until the result is taken.
module two_list_merge_core #(
  parameter int unsigned ListDepth = tlm_pkg::LIST_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tlm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tlm_pkg::out_item_t out_item_o
);

  import tlm_pkg::*;

  // Address width of a list memory and width of a counter that can hold the depth.
  localparam int unsigned AddrWidth = (ListDepth > 1) ? $clog2(ListDepth) : 1;
  localparam int unsigned CntWidth  = $clog2(ListDepth + 1);

  localparam logic StIdle  = 1'b0;
  localparam logic StMerge = 1'b1;

  logic                state_q, state_d;
  logic [CntWidth-1:0] cnt_a_q, cnt_a_d;
  logic [CntWidth-1:0] cnt_b_q, cnt_b_d;
  logic [CntWidth-1:0] ptr_a_q, ptr_a_d;
  logic [CntWidth-1:0] ptr_b_q, ptr_b_d;
  logic                drop_q, drop_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q, out_item_d;

  logic                  in_fire;
  logic                  we_a, we_b;
  logic [DATA_WIDTH-1:0] head_a, head_b;
  logic                  a_left, b_left, take_a, emit, is_last;
  logic [DATA_WIDTH-1:0] pick;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  // An append writes at the current fill count when there is room.
  assign we_a = in_fire && (in_item_i.func == FUNC_APPEND_A) && (cnt_a_q < CntWidth'(ListDepth));
  assign we_b = in_fire && (in_item_i.func == FUNC_APPEND_B) && (cnt_b_q < CntWidth'(ListDepth));

  // The memories are read at the next pointer value, so their registered outputs
  // always hold the entries at the current pointers: the heads of both lists.
  tlm_ram #(
    .Width (DATA_WIDTH),
    .Depth (ListDepth)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AddrWidth-1:0]),
    .wdata_i (in_item_i.value),
    .raddr_i (ptr_a_d[AddrWidth-1:0]),
    .rdata_o (head_a)
  );

  tlm_ram #(
    .Width (DATA_WIDTH),
    .Depth (ListDepth)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AddrWidth-1:0]),
    .wdata_i (in_item_i.value),
    .raddr_i (ptr_b_d[AddrWidth-1:0]),
    .rdata_o (head_b)
  );

  // Head selection: A wins only when strictly smaller, so B goes first on a tie.
  assign a_left  = (ptr_a_q < cnt_a_q);
  assign b_left  = (ptr_b_q < cnt_b_q);
  assign take_a  = a_left && (!b_left || ($signed(head_a) < $signed(head_b)));
  assign pick    = take_a ? head_a : head_b;
  assign is_last = take_a ? ((ptr_a_q + CntWidth'(1) == cnt_a_q) && !b_left)
                          : ((ptr_b_q + CntWidth'(1) == cnt_b_q) && !a_left);

  // A result moves into the output register when it is empty or being drained.
  assign emit = (state_q == StMerge) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    ptr_a_d     = ptr_a_q;
    ptr_b_d     = ptr_b_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_fire) begin
      unique case (in_item_i.func)
        FUNC_APPEND_A: begin
          if (we_a) begin
            cnt_a_d = cnt_a_q + CntWidth'(1);
          end else begin
            drop_d = 1'b1;
          end
        end
        FUNC_APPEND_B: begin
          if (we_b) begin
            cnt_b_d = cnt_b_q + CntWidth'(1);
          end else begin
            drop_d = 1'b1;
          end
        end
        FUNC_MERGE: begin
          // An empty merge gives no result but still clears the drop flag.
          if ((cnt_a_q == '0) && (cnt_b_q == '0)) begin
            drop_d = 1'b0;
          end else begin
            state_d = StMerge;
          end
        end
        default: begin
        end
      endcase
    end

    if (emit) begin
      out_valid_d             = 1'b1;
      out_item_d.merged_value = pick;
      out_item_d.last         = is_last;
      out_item_d.dropped      = drop_q;
      if (take_a) begin
        ptr_a_d = ptr_a_q + CntWidth'(1);
      end else begin
        ptr_b_d = ptr_b_q + CntWidth'(1);
      end
      if (is_last) begin
        state_d = StIdle;
        cnt_a_d = '0;
        cnt_b_d = '0;
        ptr_a_d = '0;
        ptr_b_d = '0;
        drop_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ptr_a_q     <= '0;
      ptr_b_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ptr_a_q     <= ptr_a_d;
      ptr_b_q     <= ptr_b_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> tb/tb_two_list_merge_core.sv
`timescale 1ns / 1ps

module tb_two_list_merge_core;
  import tlm_pkg::*;

  // The block has no code for func value 3. It must ignore such an item.
  localparam logic [1:0] FUNC_RESERVED = 2'd3;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  localparam int RANDOM_ITEMS = 30;
  localparam int HOLD_CYCLES  = 400;
  // A merge of two full lists is 2 * LIST_DEPTH results plus a head fetch.
  // Waiting that long at the end exposes any stray result.
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;
  localparam int LIMIT_CYCLES = 20000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Predictor state: both lists as they are held inside the block, plus the
  // sticky flag for refused appends. Each merge turns these into the list of
  // results that the block is expected to return.
  logic signed [31:0] held_a_q[$];
  logic signed [31:0] held_b_q[$];
  logic               drop_pending;
  out_item_t          merged_run_q[$];

  int mismatches = 0;
  int cycle_count = 0;
  int rand_items = 0;

  // The sender runs in bursts when gaps are enabled.
  bit gaps_on = 1'b0;
  int burst_left = 0;

  // Receiver state. This state is written only by the receiver process. The
  // exception is hold_req, which a test increments to ask for a long hold-off.
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         rx_slot = 0;
  logic [7:0] rx_pattern = 8'hFF;

  out_item_t want;

  two_list_merge_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #10 clk = ~clk;

  // Timeout. If the run has not finished by this point, something hung.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("two_list_merge_core: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    mismatches++;
    if (mismatches <= 40) begin
      $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, exp_v);
    end
  endtask

  // Predictor. Appends go to the tail of a list unless that list is full.
  // A merge walks both heads and takes A only when A is strictly less than B,
  // so B wins a tie. When one list is used up, the rest of the other follows.
  task automatic merge_predict(input logic [1:0] f, input logic signed [31:0] v);
    int ia;
    int ib;
    int total;
    bit take_a;
    out_item_t r;
    ia = 0;
    ib = 0;
    if (f == FUNC_APPEND_A) begin
      if (held_a_q.size() < LIST_DEPTH) held_a_q.push_back(v);
      else drop_pending = 1'b1;
    end else if (f == FUNC_APPEND_B) begin
      if (held_b_q.size() < LIST_DEPTH) held_b_q.push_back(v);
      else drop_pending = 1'b1;
    end else if (f == FUNC_MERGE) begin
      total = held_a_q.size() + held_b_q.size();
      while (ia < held_a_q.size() || ib < held_b_q.size()) begin
        if (ia < held_a_q.size() && ib < held_b_q.size()) begin
          take_a = held_a_q[ia] < held_b_q[ib];
        end else begin
          take_a = ia < held_a_q.size();
        end
        if (take_a) begin
          r.merged_value = held_a_q[ia];
          ia++;
        end else begin
          r.merged_value = held_b_q[ib];
          ib++;
        end
        r.last    = (ia + ib == total);
        r.dropped = drop_pending;
        merged_run_q.push_back(r);
      end
      held_a_q.delete();
      held_b_q.delete();
      drop_pending = 1'b0;
    end
    // An item with the reserved code changes nothing and returns no result.
  endtask

  // This task sends one item. When gaps are on, the sender first finishes its
  // current burst, then idles for a random gap. Valid goes high at a falling
  // edge and stays high until a rising edge sees ready. Only then is the item
  // applied to the predictor. Valid is left high, so a following send simply
  // replaces the payload at the next falling edge.
  task automatic send_item(input logic [1:0] f, input logic signed [31:0] v);
    int gap;
    in_item_t item;
    item.func  = f;
    item.value = v;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 10);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    merge_predict(f, v);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Receiver. It normally repeats a random ready pattern that is redrawn
  // each time rx_slot wraps. About one redraw in three is all ones, which
  // gives long stretches with no stall. A requested hold-off keeps ready low
  // until this process has counted hold_left down from HOLD_CYCLES.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (rx_slot == 0) begin
      rx_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end
    rx_slot = (rx_slot + 1) % 64;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rx_pattern[rx_slot % 8];
    end
  end

  // Result checker. Each result that is taken is compared with the oldest
  // expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (merged_run_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_item.merged_value, '0);
      end else begin
        want = merged_run_q.pop_front();
        if (out_item.merged_value !== want.merged_value) begin
          report_mismatch("merged_value", out_item.merged_value, want.merged_value);
        end
        if (out_item.last !== want.last) begin
          report_mismatch("last", 32'(out_item.last), 32'(want.last));
        end
        if (out_item.dropped !== want.dropped) begin
          report_mismatch("dropped", 32'(out_item.dropped), 32'(want.dropped));
        end
      end
    end
  end

  // This test uses both value extremes and equal heads in both lists. Across
  // MIN, -1, 0 and MAX, every value bit takes both levels. A tie must put the
  // B copy first.
  task automatic test_extremes_and_ties();
    send_item(FUNC_APPEND_A, VAL_MIN);
    send_item(FUNC_APPEND_A, -32'sd1);
    send_item(FUNC_APPEND_A, VAL_MAX);
    send_item(FUNC_APPEND_B, VAL_MIN);
    send_item(FUNC_APPEND_B, 32'sd0);
    send_item(FUNC_APPEND_B, VAL_MAX);
    send_item(FUNC_MERGE, 32'sd0);
  endtask

  // A merge with nothing stored returns nothing. Then each list is merged
  // while the other is empty.
  task automatic test_empty_and_single_list();
    send_item(FUNC_MERGE, VAL_MAX);
    send_item(FUNC_APPEND_A, 32'sd5);
    send_item(FUNC_MERGE, 32'sd0);
    send_item(FUNC_APPEND_B, -32'sd5);
    send_item(FUNC_MERGE, -32'sd1);
  endtask

  // The reserved func code must leave the lists untouched.
  task automatic test_reserved_func();
    send_item(FUNC_RESERVED, -32'sd1);
    send_item(FUNC_APPEND_B, 32'sd1);
    send_item(FUNC_MERGE, 32'sd0);
  endtask

  // Out-of-order input is not sorted by the block. The head compare runs as
  // usual on whatever values it finds.
  task automatic test_unsorted_input();
    send_item(FUNC_APPEND_A, 32'sd9);
    send_item(FUNC_APPEND_A, 32'sd2);
    send_item(FUNC_APPEND_B, 32'sd5);
    send_item(FUNC_MERGE, 32'sd0);
  endtask

  // Both lists are filled past their depth, so the extra appends are refused
  // and every result of that merge carries dropped. The receiver holds off for
  // a long time during the merge while the sender keeps offering appends. The
  // block then has to stall its input until the results drain. A second merge
  // checks that the drop flag was cleared.
  task automatic test_overflow_and_backpressure();
    logic signed [31:0] v;
    gaps_on = 1'b0;
    hold_req++;
    v = VAL_MIN;
    for (int i = 0; i <= LIST_DEPTH; i++) begin
      send_item(FUNC_APPEND_A, v);
      v = v + 32'sd3;
    end
    v = -32'sd40;
    for (int i = 0; i <= LIST_DEPTH; i++) begin
      send_item(FUNC_APPEND_B, v);
      v = v + 32'sd3;
    end
    send_item(FUNC_MERGE, 32'sd0);
    for (int i = 0; i < 6; i++) send_item(FUNC_APPEND_A, 32'(i * 7));
    send_item(FUNC_APPEND_B, 32'sd7);
    send_item(FUNC_MERGE, 32'sd0);
  endtask

  // Sorted runs are generated from a start value by climbing in random steps.
  // Steps saturate at the top of the range, so a run stays in ascending order.
  function automatic logic signed [31:0] climb(input logic signed [31:0] prev,
                                               input int unsigned spread);
    longint nxt;
    nxt = longint'(prev) + longint'($urandom_range(0, spread));
    if (nxt > longint'(VAL_MAX)) nxt = longint'(VAL_MAX);
    return nxt[31:0];
  endfunction

  function automatic logic signed [31:0] start_value(input int mode);
    if (mode == 0) return $urandom;
    if (mode == 1) return 32'(int'($urandom_range(0, 6)) - 3);
    return VAL_MIN + 32'($urandom_range(0, 3));
  endfunction

  // This task sends one list pair with random content. With the broken flag
  // set, some values are random and break the order. Appends to A and B are
  // interleaved at random. Items with the reserved code are mixed in as noise
  // and are not counted toward the random total.
  task automatic send_list_pair(input int na, input int nb, input bit broken,
                                input bit do_merge);
    logic signed [31:0] a_vals[$];
    logic signed [31:0] b_vals[$];
    logic signed [31:0] va;
    logic signed [31:0] vb;
    int mode;
    int unsigned spread;
    int ia;
    int ib;
    mode = $urandom_range(0, 2);
    spread = (mode == 0) ? (1 << 20) : (mode == 1) ? 2 : (1 << 28);
    va = start_value(mode);
    vb = start_value(mode);
    ia = 0;
    ib = 0;
    for (int i = 0; i < na; i++) begin
      a_vals.push_back((broken && $urandom_range(0, 3) == 0) ? $urandom : va);
      va = climb(va, spread);
    end
    for (int i = 0; i < nb; i++) begin
      b_vals.push_back((broken && $urandom_range(0, 3) == 0) ? $urandom : vb);
      vb = climb(vb, spread);
    end
    while (ia < na || ib < nb) begin
      if ($urandom_range(0, 15) == 0) send_item(FUNC_RESERVED, $urandom);
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 0)) begin
        send_item(FUNC_APPEND_A, a_vals[ia]);
        ia++;
      end else begin
        send_item(FUNC_APPEND_B, b_vals[ib]);
        ib++;
      end
      rand_items++;
    end
    if (do_merge) begin
      send_item(FUNC_MERGE, $urandom);
      rand_items++;
    end
  endtask

  // Most list pairs are short, and a few run past the list depth. Sometimes
  // a merge is skipped, so the next pair lands on top of the one before.
  task automatic test_random_lists();
    int na;
    int nb;
    while (rand_items < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      na = ($urandom_range(0, 9) == 0) ? $urandom_range(20, LIST_DEPTH + 2)
                                      : $urandom_range(0, 8);
      nb = ($urandom_range(0, 9) == 0) ? $urandom_range(20, LIST_DEPTH + 2)
                                      : $urandom_range(0, 8);
      send_list_pair(na, nb, $urandom_range(0, 7) == 0, $urandom_range(0, 9) != 0);
    end
    send_item(FUNC_MERGE, 32'sd0);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    drop_pending = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes_and_ties();
    test_empty_and_single_list();
    test_reserved_func();
    test_unsorted_input();
    test_overflow_and_backpressure();
    test_random_lists();
    release_input();

    // Wait until every expected result has arrived. Then keep watching long
    // enough that any extra result would show up.
    while (merged_run_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("two_list_merge_core: match");
    end else begin
      $display("two_list_merge_core: mismatch");
    end
    $finish;
  end

endmodule
